// ----- rtl/core/sast_pkg.sv -----
package sast_pkg;

  localparam int unsigned DepthDefault = 64;
  localparam int unsigned PosW = 32;
  localparam int unsigned VecW = 63;
  localparam int unsigned IdxW = 7;
  // one stored segment: start, end, radius, three packed vectors
  localparam int unsigned EntryW = 3 * PosW + 3 * VecW;

  typedef enum logic [1:0] {
    KindInsert = 2'd0,
    KindLookup = 2'd1,
    KindNext   = 2'd2,
    KindNone   = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    StatusOk      = 2'd0,
    StatusMiss    = 2'd1,
    StatusInvalid = 2'd2,
    StatusFull    = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    StIdle,
    StScan,
    StShift,
    StWrite,
    StRead,
    StDone
  } state_e;

  typedef struct packed {
    logic [1:0]             kind;
    logic signed [PosW-1:0] seg_start;
    logic signed [PosW-1:0] seg_end;
    logic signed [PosW-1:0] arc_radius;
    logic [VecW-1:0]        x_axis;
    logic [VecW-1:0]        y_axis;
    logic [VecW-1:0]        center_point;
    logic signed [PosW-1:0] query_point;
  } req_t;

  typedef struct packed {
    logic [1:0]             status;
    logic signed [PosW-1:0] out_start;
    logic signed [PosW-1:0] out_end;
    logic signed [PosW-1:0] out_radius;
    logic [VecW-1:0]        out_x_axis;
    logic [VecW-1:0]        out_y_axis;
    logic [VecW-1:0]        out_center;
    logic [IdxW-1:0]        out_index;
  } rsp_t;

endpackage

// ----- rtl/core/sorted_arc_segment_table.sv -----
// channel  | direction | ports                   | transaction
// command  | in        | start_i, busy_o, req_i  | start_i high while busy_o low
// result   | out       | done_o, rsp_o           | one cycle at done_o high
//
// insert scans down from the top, moving each entry with a greater start
// up one place, then writes the new entry; lookup scans forward from
// entry 0; read-next reads the entry at the cursor; kind 3 and rejects
// go straight to the result. the entry memory has one registered read
// port. reset clears state, entry count, cursor and pointer only. the
// receiver cannot stall; busy_o stays high until the result cycle ends.
module sorted_arc_segment_table #(
  parameter int unsigned Depth = sast_pkg::DepthDefault
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  sast_pkg::req_t req_i,
  output logic           busy_o,
  output logic           done_o,
  output sast_pkg::rsp_t rsp_o
);
  import sast_pkg::*;

  localparam int unsigned AW = $clog2(Depth);
  localparam int unsigned CW = $clog2(Depth + 1);

  state_e            state_q, state_d;
  req_t              req_q, req_d;
  rsp_t              rsp_q, rsp_d;
  logic [CW-1:0]     count_q, count_d;
  logic [CW-1:0]     cursor_q, cursor_d;
  logic [CW-1:0]     ptr_q, ptr_d;
  logic              we;
  logic [AW-1:0]     waddr, raddr;
  logic [EntryW-1:0] wdata, rdata;

  logic signed [PosW-1:0] rd_start, rd_end, rd_radius;
  logic [VecW-1:0]        rd_x, rd_y, rd_c;

  assign {rd_start, rd_end, rd_radius, rd_x, rd_y, rd_c} = rdata;

  sast_ram #(.Width(EntryW), .Depth(Depth)) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  function automatic logic [IdxW-1:0] to_idx(input logic [CW-1:0] v);
    logic [IdxW+CW-1:0] t;
    t = {{IdxW{1'b0}}, v};
    return t[IdxW-1:0];
  endfunction

  // registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      count_q  <= '0;
      cursor_q <= '0;
      ptr_q    <= '0;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      cursor_q <= cursor_d;
      ptr_q    <= ptr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q <= req_d;
    rsp_q <= rsp_d;
  end

  // sequencer
  always_comb begin
    logic [CW-1:0] pm1;
    pm1      = ptr_q - CW'(1);
    state_d  = state_q;
    req_d    = req_q;
    rsp_d    = rsp_q;
    count_d  = count_q;
    cursor_d = cursor_q;
    ptr_d    = ptr_q;
    we       = 1'b0;
    waddr    = pm1[AW-1:0];
    wdata    = rdata;
    raddr    = pm1[AW-1:0];
    case (state_q)
      StIdle: begin
        if (start_i) begin
          req_d = req_i;
          rsp_d = '0;
          rsp_d.out_index = to_idx(count_q);
          state_d = StDone;
          case (kind_e'(req_i.kind))
            KindInsert: begin
              if (req_i.seg_end <= req_i.seg_start || req_i.arc_radius < 0) begin
                rsp_d.status = StatusInvalid;
              end else if (count_q == CW'(Depth)) begin
                rsp_d.status = StatusFull;
              end else begin
                ptr_d = count_q;
                state_d = StShift;
                // fetch the entry just below the insertion candidate
                raddr = AW'(count_q - CW'(1));
              end
            end
            KindLookup: begin
              ptr_d = '0;
              raddr = '0;
              rsp_d.status = StatusMiss;
              if (count_q != '0) state_d = StScan;
            end
            KindNext: begin
              rsp_d.status = StatusMiss;
              if (cursor_q < count_q) begin
                raddr = cursor_q[AW-1:0];
                state_d = StRead;
              end
            end
            default: rsp_d.status = StatusMiss;
          endcase
        end
      end
      // forward scan for the first range holding the query
      StScan: begin
        raddr = AW'(ptr_q + CW'(1));
        if (rd_start <= req_q.query_point && rd_end >= req_q.query_point) begin
          rsp_d = {StatusOk, rdata, to_idx(ptr_q)};
          cursor_d = ptr_q;
          state_d = StDone;
        end else if (ptr_q + CW'(1) >= count_q) begin
          state_d = StDone;
        end else begin
          ptr_d = ptr_q + CW'(1);
        end
      end
      // rdata holds entry ptr-1; move it up while its start is greater
      StShift: begin
        if (ptr_q != '0 && rd_start > req_q.seg_start) begin
          we = 1'b1;
          waddr = ptr_q[AW-1:0];
          wdata = rdata;
          ptr_d = pm1;
          raddr = AW'(pm1 - CW'(1));
        end else begin
          state_d = StWrite;
        end
      end
      StWrite: begin
        we = 1'b1;
        waddr = ptr_q[AW-1:0];
        wdata = {req_q.seg_start, req_q.seg_end, req_q.arc_radius,
                 req_q.x_axis, req_q.y_axis, req_q.center_point};
        count_d = count_q + CW'(1);
        rsp_d.status = StatusOk;
        rsp_d.out_index = to_idx(ptr_q);
        state_d = StDone;
      end
      StRead: begin
        rsp_d = {StatusOk, rdata, to_idx(cursor_q)};
        cursor_d = cursor_q + CW'(1);
        state_d = StDone;
      end
      StDone: state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  assign busy_o = (state_q != StIdle);
  assign done_o = (state_q == StDone);
  assign rsp_o  = rsp_q;

endmodule

// ----- rtl/core/sast_ram.sv -----
module sast_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ----- tb/sorted_arc_segment_table_tb.sv -----
`timescale 1ns / 1ps

module sorted_arc_segment_table_tb;
  import sast_pkg::*;

  localparam int unsigned Depth = 64;
  localparam longint CycleLimit = 2_000_000;

  logic clk_i;
  logic rst_ni;
  logic start_i;
  req_t req_i;
  logic busy_o;
  logic done_o;
  rsp_t rsp_o;

  sorted_arc_segment_table #(.Depth(Depth)) i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start_i),
    .req_i  (req_i),
    .busy_o (busy_o),
    .done_o (done_o),
    .rsp_o  (rsp_o)
  );

  // shadow copy of the segment table
  req_t        seg_table[Depth];
  int unsigned seg_count;
  int unsigned read_cursor;

  rsp_t   expected_rsps[$];
  int     error_count;
  longint cycle_count;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input logic [255:0] got,
                                 input logic [255:0] want);
    $display("mismatch %s: got %0h want %0h", what, got, want);
    error_count++;
  endtask

  function automatic rsp_t segment_rsp(status_e st, int unsigned idx, bit have);
    rsp_t r;
    r = '0;
    r.status = st;
    r.out_index = idx[IdxW-1:0];
    if (have) begin
      r.out_start  = seg_table[idx].seg_start;
      r.out_end    = seg_table[idx].seg_end;
      r.out_radius = seg_table[idx].arc_radius;
      r.out_x_axis = seg_table[idx].x_axis;
      r.out_y_axis = seg_table[idx].y_axis;
      r.out_center = seg_table[idx].center_point;
    end
    return r;
  endfunction

  // predicts the result of one command and updates the shadow table
  function automatic rsp_t predict_table_op(req_t rq);
    int unsigned pos;
    case (kind_e'(rq.kind))
      KindInsert: begin
        if (rq.seg_end <= rq.seg_start || rq.arc_radius < 0)
          return segment_rsp(StatusInvalid, seg_count, 0);
        if (seg_count >= Depth) return segment_rsp(StatusFull, seg_count, 0);
        pos = seg_count;
        while (pos > 0 && seg_table[pos-1].seg_start > rq.seg_start) begin
          seg_table[pos] = seg_table[pos-1];
          pos--;
        end
        seg_table[pos] = rq;
        seg_count++;
        return segment_rsp(StatusOk, pos, 0);
      end
      KindLookup: begin
        for (int unsigned i = 0; i < seg_count; i++) begin
          if (seg_table[i].seg_start <= rq.query_point &&
              seg_table[i].seg_end >= rq.query_point) begin
            read_cursor = i;
            return segment_rsp(StatusOk, i, 1);
          end
        end
        return segment_rsp(StatusMiss, seg_count, 0);
      end
      KindNext: begin
        if (read_cursor >= seg_count) return segment_rsp(StatusMiss, seg_count, 0);
        read_cursor++;
        return segment_rsp(StatusOk, read_cursor - 1, 1);
      end
      default: return segment_rsp(StatusMiss, seg_count, 0);
    endcase
  endfunction

  // result checker
  always @(posedge clk_i) begin
    rsp_t want;
    if (rst_ni && done_o) begin
      if (expected_rsps.size() == 0) begin
        $display("unexpected result transaction");
        error_count++;
      end else begin
        want = expected_rsps.pop_front();
        if (rsp_o.status !== want.status)
          report_mismatch("status", rsp_o.status, want.status);
        if (rsp_o.out_start !== want.out_start)
          report_mismatch("out_start", rsp_o.out_start, want.out_start);
        if (rsp_o.out_end !== want.out_end)
          report_mismatch("out_end", rsp_o.out_end, want.out_end);
        if (rsp_o.out_radius !== want.out_radius)
          report_mismatch("out_radius", rsp_o.out_radius, want.out_radius);
        if (rsp_o.out_x_axis !== want.out_x_axis)
          report_mismatch("out_x_axis", rsp_o.out_x_axis, want.out_x_axis);
        if (rsp_o.out_y_axis !== want.out_y_axis)
          report_mismatch("out_y_axis", rsp_o.out_y_axis, want.out_y_axis);
        if (rsp_o.out_center !== want.out_center)
          report_mismatch("out_center", rsp_o.out_center, want.out_center);
        if (rsp_o.out_index !== want.out_index)
          report_mismatch("out_index", rsp_o.out_index, want.out_index);
      end
    end
  end

  // drive one command transaction, with a random gap first when asked
  task automatic send_command(req_t rq, bit gap = 1);
    int unsigned idle;
    rsp_t        want;
    idle = gap ? $urandom_range(0, 15) : 0;
    if ($urandom_range(0, 3) == 0) idle = 0;
    repeat (idle) @(negedge clk_i);
    start_i = 1'b1;
    req_i   = rq;
    // busy_o only moves at rising edges, so it is stable here
    while (busy_o) @(negedge clk_i);
    @(posedge clk_i);
    want = predict_table_op(rq);
    expected_rsps = {expected_rsps, want};
    @(negedge clk_i);
    start_i = 1'b0;
    req_i   = '0;
  endtask

  function automatic logic [VecW-1:0] rand_vec();
    logic [63:0] v;
    v = {$urandom(), $urandom()};
    return v[VecW-1:0];
  endfunction

  function automatic req_t make_insert(int s, int e, int r);
    req_t rq;
    rq = '0;
    rq.kind = KindInsert;
    rq.seg_start = s;
    rq.seg_end = e;
    rq.arc_radius = r;
    rq.x_axis = rand_vec();
    rq.y_axis = rand_vec();
    rq.center_point = rand_vec();
    rq.query_point = $urandom();
    return rq;
  endfunction

  function automatic req_t make_query(kind_e k, int q);
    req_t rq;
    rq = make_insert($urandom(), $urandom(), $urandom());
    rq.kind = k;
    rq.query_point = q;
    return rq;
  endfunction

  // empty table, extremes, rejects, kind 3
  task automatic test_directed();
    send_command(make_query(KindNext, 0));
    send_command(make_query(KindLookup, 0));
    send_command(make_query(KindNone, 0));
    send_command(make_insert(5, 5, 1));
    send_command(make_insert(5, 4, 1));
    send_command(make_insert(0, 10, -1));
    send_command(make_insert(32'sh8000_0000, 32'sh7fff_ffff, 32'sh7fff_ffff));
    send_command(make_insert(100, 200, 0));
    send_command(make_insert(100, 150, 3));
    send_command(make_insert(-50, 100, 7));
    begin
      req_t rq;
      rq = make_insert(300, 400, 1);
      rq.x_axis = '1; rq.y_axis = '1; rq.center_point = '1;
      send_command(rq);
    end
    send_command(make_query(KindLookup, 32'sh8000_0000));
    send_command(make_query(KindLookup, 32'sh7fff_ffff));
    send_command(make_query(KindLookup, 150));
    send_command(make_query(KindLookup, 400));
    send_command(make_query(KindLookup, 200));
    repeat (7) send_command(make_query(KindNext, 0));
  endtask

  // fill to full, then rejects, a lookup and read-next past the end on a full table
  task automatic test_full_table();
    while (seg_count < Depth)
      send_command(make_insert($urandom_range(0, 40), 1000, $urandom_range(0, 9)), 0);
    send_command(make_insert(1, 2, 0));
    send_command(make_insert(2, 1, 0));
    send_command(make_query(KindLookup, 20));
    repeat (Depth + 2) send_command(make_query(KindNext, 0), 0);
  endtask

  // random mix of inserts, lookups, read-next and kind 3 commands
  task automatic test_random(int unsigned n);
    req_t rq;
    int s;
    int unsigned mode;
    for (int unsigned i = 0; i < n; i++) begin
      mode = $urandom_range(0, 99);
      if (mode < 45) begin
        // mostly narrow starts; on the full table these inserts are rejected
        s = ($urandom_range(0, 3) == 0) ? int'($urandom()) : $urandom_range(0, 400) - 200;
        if ($urandom_range(0, 9) == 0)
          rq = make_insert(s, $urandom(), $urandom());
        else
          rq = make_insert(s, s + $urandom_range(1, 120), $urandom_range(0, 1 << 20));
      end else if (mode < 75) begin
        rq = make_query(KindLookup, ($urandom_range(0, 7) == 0) ? int'($urandom())
                                     : $urandom_range(0, 600) - 250);
      end else if (mode < 97) begin
        rq = make_query(KindNext, 0);
      end else begin
        rq = make_query(KindNone, 0);
      end
      send_command(rq);
    end
  endtask

  initial begin
    rst_ni      = 1'b0;
    start_i     = 1'b0;
    req_i       = '0;
    seg_count   = 0;
    read_cursor = 0;
    error_count = 0;
    cycle_count = 0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_directed();
    test_full_table();
    // the table stays full from here, so random traffic runs on a full table
    test_random(1700);

    wait (expected_rsps.size() == 0);
    repeat (2 * Depth + 10) @(posedge clk_i);
    if (error_count == 0 && expected_rsps.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
